@@ sv/crcpr_pkg.sv @@
// Shared types and constants of the CRC-checked packet receiver.
`default_nettype none

package crcpr_pkg;

    localparam logic [7:0] CRC_POLY  = 8'h2F;
    localparam logic [3:0] CRC_STEPS = 4'd8;
    localparam logic [7:0] FILL_BYTE = 8'hFF;

    localparam logic KIND_LINK = 1'b0;
    localparam logic KIND_READ = 1'b1;
    localparam logic DEST_LINK = 1'b0;
    localparam logic DEST_HOST = 1'b1;

    typedef enum logic [2:0] {
        REG_ACK_CODE   = 3'd0,
        REG_RETX_CODE  = 3'd1,
        REG_ACK_CRC    = 3'd2,
        REG_RETX_CRC   = 3'd3,
        REG_CRC_INIT   = 3'd4,
        REG_CRC_XOROUT = 3'd5
    } t_reg;

    typedef struct packed {
        logic       load;
        logic [7:0] seed;
    } t_crc_ctl;

endpackage

`default_nettype wire

@@ sv/crc_checked_packet_receiver_core.sv @@
// Top level of the CRC-checked packet receiver with acknowledge and retransmit.
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_valid / o_stall          i_kind, i_rx_byte
//  result    out        o_valid / i_stall          o_out_byte, o_dest, o_last,
//                                                  o_empty_res, o_available
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A link length or data byte stalls the input until the CRC unit has shifted it in
// at one bit per cycle. The CRC byte of a packet other than a good acknowledge is
// answered by DATA_BYTES+2 reply bytes at one byte per cycle while the result side
// does not stall. A host read fetches each byte through the registered read port of
// the ring memory; an empty read gives one result. Reset is synchronous; no clearing
// pass is needed. A stall on the result side holds the emission sequence in place.
`default_nettype none

module crc_checked_packet_receiver_core #(
    parameter int DATA_BYTES = 16,
    parameter int SLOTS      = 8
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire        i_kind,
    input  wire [7:0]  i_rx_byte,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_dest,
    output logic       o_last,
    output logic       o_empty_res,
    output logic       o_available,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [2:0]  i_cfg_index,
    input  wire [7:0]  i_cfg_data
);

    localparam int PKT_LEN = DATA_BYTES + 2;
    localparam int DEPTH   = SLOTS * PKT_LEN;
    localparam int AW      = $clog2(DEPTH);
    localparam int SW      = $clog2(SLOTS);
    localparam int KW      = $clog2(PKT_LEN);
    localparam int DCW     = $clog2(DATA_BYTES + 1);

    localparam logic [KW-1:0]  K_LAST    = KW'(PKT_LEN - 1);
    localparam logic [DCW-1:0] DC_LAST   = DCW'(DATA_BYTES - 1);
    localparam logic [SW-1:0]  SLOT_LAST = SW'(SLOTS - 1);
    localparam logic [AW-1:0]  BASE_LAST = AW'((SLOTS - 1) * PKT_LEN);
    localparam logic [AW-1:0]  BASE_STEP = AW'(PKT_LEN);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CRC    = 6'b000010,
        S_SEND   = 6'b000100,
        S_EMPTY  = 6'b001000,
        S_HFETCH = 6'b010000,
        S_HLOAD  = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        PH_LEN  = 3'b001,
        PH_DATA = 3'b010,
        PH_CRC  = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        W_ZERO = 2'd0,
        W_ACK  = 2'd1,
        W_RETX = 2'd2
    } t_which;

    t_state         r_state, n_state;
    t_phase         r_phase, n_phase;
    logic [DCW-1:0] r_dc, n_dc;
    logic [7:0]     r_rx_len, n_rx_len;
    logic [7:0]     r_rx_first, n_rx_first;
    logic           r_rest_ff, n_rest_ff;
    logic [SW-1:0]  r_wslot, n_wslot;
    logic [SW-1:0]  r_rslot, n_rslot;
    logic [AW-1:0]  r_wbase, n_wbase;
    logic [AW-1:0]  r_rbase, n_rbase;
    logic [AW-1:0]  r_rd_addr, n_rd_addr;
    logic [KW-1:0]  r_k, n_k;
    t_which         r_which, n_which;
    t_which         r_last_sent, n_last_sent;

    logic           r_ovalid, n_ovalid;
    logic [7:0]     r_obyte, n_obyte;
    logic           r_odest, n_odest;
    logic           r_olast, n_olast;
    logic           r_oempty, n_oempty;
    logic           r_oavail, n_oavail;

    logic [7:0]     r_ack_code, n_ack_code;
    logic [7:0]     r_retx_code, n_retx_code;
    logic [7:0]     r_ack_crc, n_ack_crc;
    logic [7:0]     r_retx_crc, n_retx_crc;
    logic [7:0]     r_crc_init, n_crc_init;
    logic [7:0]     r_crc_xorout, n_crc_xorout;

    crcpr_pkg::t_crc_ctl crc_ctl;
    logic [7:0]     crc_val;
    logic           crc_busy;

    logic           in_acc;
    logic           out_free;
    logic           avail;
    logic           ctl_shape;
    logic [KW-1:0]  wr_off;
    logic [AW-1:0]  wr_addr;
    logic           wr_en;
    logic [7:0]     rd_data;
    logic [7:0]     send_byte;
    logic [7:0]     send_code;
    logic [7:0]     send_crc;

    crcpr_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_crc   (crc_val),
        .o_busy  (crc_busy)
    );

    crcpr_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_rx_byte),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_data)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign in_acc      = i_valid && (r_state == S_IDLE);
    assign out_free    = !r_ovalid || !i_stall;
    assign avail       = (r_rslot != r_wslot);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        case (r_phase)
            PH_LEN:  wr_off = '0;
            PH_DATA: wr_off = KW'(r_dc) + KW'(1);
            PH_CRC:  wr_off = K_LAST;
            default: wr_off = '0;
        endcase
    end

    assign wr_addr = r_wbase + AW'(wr_off);
    assign wr_en   = in_acc && (i_kind == crcpr_pkg::KIND_LINK);

    assign crc_ctl.load = in_acc && (i_kind == crcpr_pkg::KIND_LINK) && (r_phase != PH_CRC);
    assign crc_ctl.seed = ((r_phase == PH_LEN) ? r_crc_init : crc_val) ^ i_rx_byte;

    assign ctl_shape = (r_rx_len == 8'd1) && r_rest_ff;

    assign send_code = (r_which == W_ACK) ? r_ack_code : r_retx_code;
    assign send_crc  = (r_which == W_ACK) ? r_ack_crc : r_retx_crc;

    always_comb begin
        if (r_which == W_ZERO) begin
            send_byte = 8'd0;
        end else if (r_k == '0) begin
            send_byte = 8'd1;
        end else if (r_k == KW'(1)) begin
            send_byte = send_code;
        end else if (r_k == K_LAST) begin
            send_byte = send_crc;
        end else begin
            send_byte = crcpr_pkg::FILL_BYTE;
        end
    end

    always_comb begin
        n_ack_code   = r_ack_code;
        n_retx_code  = r_retx_code;
        n_ack_crc    = r_ack_crc;
        n_retx_crc   = r_retx_crc;
        n_crc_init   = r_crc_init;
        n_crc_xorout = r_crc_xorout;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                crcpr_pkg::REG_ACK_CODE:   n_ack_code   = i_cfg_data;
                crcpr_pkg::REG_RETX_CODE:  n_retx_code  = i_cfg_data;
                crcpr_pkg::REG_ACK_CRC:    n_ack_crc    = i_cfg_data;
                crcpr_pkg::REG_RETX_CRC:   n_retx_crc   = i_cfg_data;
                crcpr_pkg::REG_CRC_INIT:   n_crc_init   = i_cfg_data;
                crcpr_pkg::REG_CRC_XOROUT: n_crc_xorout = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_dc        = r_dc;
        n_rx_len    = r_rx_len;
        n_rx_first  = r_rx_first;
        n_rest_ff   = r_rest_ff;
        n_wslot     = r_wslot;
        n_rslot     = r_rslot;
        n_wbase     = r_wbase;
        n_rbase     = r_rbase;
        n_rd_addr   = r_rd_addr;
        n_k         = r_k;
        n_which     = r_which;
        n_last_sent = r_last_sent;
        n_ovalid    = r_ovalid && i_stall;
        n_obyte     = r_obyte;
        n_odest     = r_odest;
        n_olast     = r_olast;
        n_oempty    = r_oempty;
        n_oavail    = r_oavail;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_kind == crcpr_pkg::KIND_READ) begin
                        if (!avail) begin
                            n_state = S_EMPTY;
                        end else begin
                            n_rd_addr = r_rbase;
                            n_rbase   = (r_rbase == BASE_LAST) ? '0 : r_rbase + BASE_STEP;
                            n_rslot   = (r_rslot == SLOT_LAST) ? '0 : r_rslot + SW'(1);
                            n_k       = '0;
                            n_state   = S_HFETCH;
                        end
                    end else begin
                        case (r_phase)
                            PH_LEN: begin
                                n_rx_len  = i_rx_byte;
                                n_dc      = '0;
                                n_rest_ff = 1'b1;
                                n_phase   = PH_DATA;
                                n_state   = S_CRC;
                            end
                            PH_DATA: begin
                                if (r_dc == '0) begin
                                    n_rx_first = i_rx_byte;
                                end else if (i_rx_byte != crcpr_pkg::FILL_BYTE) begin
                                    n_rest_ff = 1'b0;
                                end
                                if (r_dc == DC_LAST) begin
                                    n_dc    = '0;
                                    n_phase = PH_CRC;
                                end else begin
                                    n_dc = r_dc + DCW'(1);
                                end
                                n_state = S_CRC;
                            end
                            PH_CRC: begin
                                n_phase = PH_LEN;
                                n_k     = '0;
                                if ((crc_val ^ r_crc_xorout) != i_rx_byte) begin
                                    n_which     = W_RETX;
                                    n_last_sent = W_RETX;
                                    n_state     = S_SEND;
                                end else if (ctl_shape && (r_rx_first == r_retx_code)) begin
                                    n_which = r_last_sent;
                                    n_state = S_SEND;
                                end else if (ctl_shape && (r_rx_first == r_ack_code)) begin
                                    n_state = S_IDLE;
                                end else begin
                                    n_wslot     = (r_wslot == SLOT_LAST) ? '0 : r_wslot + SW'(1);
                                    n_wbase     = (r_wbase == BASE_LAST) ? '0
                                                                         : r_wbase + BASE_STEP;
                                    n_which     = W_ACK;
                                    n_last_sent = W_ACK;
                                    n_state     = S_SEND;
                                end
                            end
                            default: n_phase = PH_LEN;
                        endcase
                    end
                end
            end
            S_CRC: begin
                if (!crc_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_SEND: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = send_byte;
                    n_odest  = crcpr_pkg::DEST_LINK;
                    n_olast  = (r_k == K_LAST);
                    n_oempty = 1'b0;
                    n_oavail = avail;
                    if (r_k == K_LAST) begin
                        n_k     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + KW'(1);
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = 8'd0;
                    n_odest  = crcpr_pkg::DEST_HOST;
                    n_olast  = 1'b0;
                    n_oempty = 1'b1;
                    n_oavail = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_HFETCH: begin
                n_state = S_HLOAD;
            end
            S_HLOAD: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = rd_data;
                    n_odest  = crcpr_pkg::DEST_HOST;
                    n_olast  = (r_k == K_LAST);
                    n_oempty = 1'b0;
                    n_oavail = avail;
                    if (r_k == K_LAST) begin
                        n_k     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k       = r_k + KW'(1);
                        n_rd_addr = r_rd_addr + AW'(1);
                        n_state   = S_HFETCH;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_LEN;
            r_dc         <= '0;
            r_wslot      <= '0;
            r_rslot      <= '0;
            r_wbase      <= '0;
            r_rbase      <= '0;
            r_k          <= '0;
            r_last_sent  <= W_ZERO;
            r_ovalid     <= 1'b0;
            r_ack_code   <= 8'd21;
            r_retx_code  <= 8'd25;
            r_ack_crc    <= 8'hCC;
            r_retx_crc   <= 8'hFC;
            r_crc_init   <= 8'hFF;
            r_crc_xorout <= 8'hFF;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_dc         <= n_dc;
            r_wslot      <= n_wslot;
            r_rslot      <= n_rslot;
            r_wbase      <= n_wbase;
            r_rbase      <= n_rbase;
            r_k          <= n_k;
            r_last_sent  <= n_last_sent;
            r_ovalid     <= n_ovalid;
            r_ack_code   <= n_ack_code;
            r_retx_code  <= n_retx_code;
            r_ack_crc    <= n_ack_crc;
            r_retx_crc   <= n_retx_crc;
            r_crc_init   <= n_crc_init;
            r_crc_xorout <= n_crc_xorout;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx_len   <= n_rx_len;
        r_rx_first <= n_rx_first;
        r_rest_ff  <= n_rest_ff;
        r_rd_addr  <= n_rd_addr;
        r_which    <= n_which;
        r_obyte    <= n_obyte;
        r_odest    <= n_odest;
        r_olast    <= n_olast;
        r_oempty   <= n_oempty;
        r_oavail   <= n_oavail;
    end

    assign o_valid     = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_dest      = r_odest;
    assign o_last      = r_olast;
    assign o_empty_res = r_oempty;
    assign o_available = r_oavail;

    // The CRC unit only runs while the controller waits on it.
    a_crc_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        crc_busy |-> (r_state == S_CRC))
        else $error("CRC unit busy outside its wait state");

    // Slot indexes and ring base addresses must move together.
    a_ring_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_wslot == r_rslot) == (r_wbase == r_rbase)))
        else $error("Ring slot index and base address disagree");

    // A packet's CRC byte always closes the frame.
    a_frame_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_kind && (r_phase == PH_CRC)) |=> (r_phase == PH_LEN))
        else $error("Frame did not return to the length byte");

    // Once idle, a pending result can only be the end of an emission.
    a_idle_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && r_ovalid) |-> (r_olast || r_oempty))
        else $error("Controller idle in the middle of a packet");

endmodule

`default_nettype wire

@@ sv/crcpr_crc.sv @@
// Bit-serial CRC-8 unit that shifts one message bit per cycle.
`default_nettype none

module crcpr_crc (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  crcpr_pkg::t_crc_ctl  i_ctl,
    output logic [7:0]           o_crc,
    output logic                 o_busy
);

    logic [7:0] r_sr;
    logic [7:0] n_sr;
    logic [3:0] r_cnt;
    logic [3:0] n_cnt;

    always_comb begin
        n_sr  = r_sr;
        n_cnt = r_cnt;
        if (i_ctl.load) begin
            n_sr  = i_ctl.seed;
            n_cnt = crcpr_pkg::CRC_STEPS;
        end else if (r_cnt != 4'd0) begin
            n_sr  = r_sr[7] ? ({r_sr[6:0], 1'b0} ^ crcpr_pkg::CRC_POLY)
                            : {r_sr[6:0], 1'b0};
            n_cnt = r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 4'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr <= n_sr;
    end

    assign o_crc  = r_sr;
    assign o_busy = (r_cnt != 4'd0);

endmodule

`default_nettype wire

@@ sv/crcpr_store.sv @@
// Packet ring memory with one write port and one registered read port.
`default_nettype none

module crcpr_store #(
    parameter int DEPTH = 144,
    parameter int AW    = 8
) (
    input  wire          i_clk,
    input  wire          i_we,
    input  wire [AW-1:0] i_waddr,
    input  wire [7:0]    i_wdata,
    input  wire [AW-1:0] i_raddr,
    output logic [7:0]   o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ tb/sv/crc_checked_packet_receiver_core_tb.sv @@
// Self-checking testbench of the CRC-checked packet receiver core.
module crc_checked_packet_receiver_core_tb;

    localparam int DATA_BYTES    = 16;
    localparam int SLOTS         = 8;
    localparam int PKT_LEN       = DATA_BYTES + 2;
    localparam int SETTLE_CYCLES = 40;

    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {RX_LEN, RX_DATA, RX_CRC} t_rx_phase;
    typedef enum logic [1:0] {SENT_ZERO, SENT_ACK, SENT_RETX} t_sent;
    typedef enum logic [1:0] {BODY_RANDOM, BODY_FILL, BODY_SPOILED} t_body;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_request;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       dest;
        logic       last;
        logic       empty_res;
        logic       available;
    } t_reply;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_kind      = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_stall     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [2:0] i_cfg_index = 3'd0;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_dest;
    logic       o_last;
    logic       o_empty_res;
    logic       o_available;
    logic       o_cfg_ready;

    crc_checked_packet_receiver_core #(
        .DATA_BYTES(DATA_BYTES),
        .SLOTS     (SLOTS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_kind     (i_kind),
        .i_rx_byte  (i_rx_byte),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_dest     (o_dest),
        .o_last     (o_last),
        .o_empty_res(o_empty_res),
        .o_available(o_available),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Register copies used both by the receiver prediction and by the frame builder.
    logic [7:0] cfg_ack_code   = 8'd21;
    logic [7:0] cfg_retx_code  = 8'd25;
    logic [7:0] cfg_ack_crc    = 8'd204;
    logic [7:0] cfg_retx_crc   = 8'd252;
    logic [7:0] cfg_crc_init   = 8'd255;
    logic [7:0] cfg_crc_xorout = 8'd255;

    t_rx_phase  rx_phase   = RX_LEN;
    int         body_count = 0;
    logic [7:0] hdr_len    = 8'h00;
    logic [7:0] hdr_first  = 8'h00;
    logic       tail_ff    = 1'b1;
    logic [7:0] crc_run    = 8'hFF;
    logic [7:0] pkt_mem [SLOTS][PKT_LEN];
    int         wr_slot    = 0;
    int         rd_slot    = 0;
    t_sent      sent_kind  = SENT_ZERO;

    t_request request_q [$];
    t_reply   reply_q [$];
    int       pushed_requests   = 0;
    int       accepted_requests = 0;
    int       gen_pos           = 0;
    int       gap_left          = 0;
    int       stall_left        = 0;
    int       n_errors          = 0;
    logic     calm              = 1'b0;

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ crcpr_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic void add_reply(input logic [7:0] b, input logic dest, input logic last,
                                      input logic empty, input logic avail);
        t_reply r;
        r.out_byte  = b;
        r.dest      = dest;
        r.last      = last;
        r.empty_res = empty;
        r.available = avail;
        reply_q.push_back(r);
    endfunction

    function automatic void send_link_packet(input t_sent which);
        logic       avail;
        logic [7:0] v;
        avail = rd_slot != wr_slot;
        for (int k = 0; k < PKT_LEN; k++) begin
            if (which == SENT_ZERO) begin
                v = 8'h00;
            end else if (k == 0) begin
                v = 8'd1;
            end else if (k == 1) begin
                v = (which == SENT_ACK) ? cfg_ack_code : cfg_retx_code;
            end else if (k == PKT_LEN - 1) begin
                v = (which == SENT_ACK) ? cfg_ack_crc : cfg_retx_crc;
            end else begin
                v = crcpr_pkg::FILL_BYTE;
            end
            add_reply(v, crcpr_pkg::DEST_LINK, k == PKT_LEN - 1, 1'b0, avail);
        end
        sent_kind = which;
    endfunction

    function automatic void predict(input logic kind, input logic [7:0] b);
        int   src;
        logic is_ctl;
        if (kind == crcpr_pkg::KIND_READ) begin
            if (rd_slot == wr_slot) begin
                add_reply(8'h00, crcpr_pkg::DEST_HOST, 1'b0, 1'b1, 1'b0);
            end else begin
                src = rd_slot;
                rd_slot = (rd_slot + 1) % SLOTS;
                for (int k = 0; k < PKT_LEN; k++) begin
                    add_reply(pkt_mem[src][k], crcpr_pkg::DEST_HOST, k == PKT_LEN - 1, 1'b0,
                              rd_slot != wr_slot);
                end
            end
        end else begin
            case (rx_phase)
                RX_LEN: begin
                    hdr_len = b;
                    pkt_mem[wr_slot][0] = b;
                    crc_run = crc8_update(cfg_crc_init, b);
                    body_count = 0;
                    tail_ff = 1'b1;
                    rx_phase = RX_DATA;
                end
                RX_DATA: begin
                    if (body_count == 0) begin
                        hdr_first = b;
                    end else if (b != crcpr_pkg::FILL_BYTE) begin
                        tail_ff = 1'b0;
                    end
                    pkt_mem[wr_slot][1 + body_count] = b;
                    crc_run = crc8_update(crc_run, b);
                    body_count++;
                    if (body_count >= DATA_BYTES) begin
                        body_count = 0;
                        rx_phase = RX_CRC;
                    end
                end
                default: begin
                    rx_phase = RX_LEN;
                    pkt_mem[wr_slot][PKT_LEN - 1] = b;
                    is_ctl = (hdr_len == 8'd1) && tail_ff;
                    if ((crc_run ^ cfg_crc_xorout) != b) begin
                        send_link_packet(SENT_RETX);
                    end else if (is_ctl && hdr_first == cfg_retx_code) begin
                        send_link_packet(sent_kind);
                    end else if (!(is_ctl && hdr_first == cfg_ack_code)) begin
                        wr_slot = (wr_slot + 1) % SLOTS;
                        send_link_packet(SENT_ACK);
                    end
                end
            endcase
        end
    endfunction

    always @(posedge i_clk) begin : drive_requests
        t_request nxt;
        if (i_rst_n && (!i_valid || !o_stall)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(0, 17);
                i_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
                nxt = request_q.pop_front();
                i_valid <= 1'b1;
                i_kind <= nxt.kind;
                i_rx_byte <= nxt.data;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_reply got;
        t_reply want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                accepted_requests++;
                predict(i_kind, i_rx_byte);
            end
            if (o_valid && !i_stall) begin
                got.out_byte  = o_out_byte;
                got.dest      = o_dest;
                got.last      = o_last;
                got.empty_res = o_empty_res;
                got.available = o_available;
                if (reply_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result: expected none, ", $time,
                             "got byte=%h dest=%b last=%b empty=%b avail=%b",
                             got.out_byte, got.dest, got.last, got.empty_res,
                             got.available);
                end else begin
                    want = reply_q.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        $display("%0t: result mismatch: ", $time,
                                 "expected byte=%h dest=%b last=%b empty=%b avail=%b, ",
                                 want.out_byte, want.dest, want.last, want.empty_res,
                                 want.available,
                                 "got byte=%h dest=%b last=%b empty=%b avail=%b",
                                 got.out_byte, got.dest, got.last,
                                 got.empty_res, got.available);
                    end
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 17);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic void push_request(input logic kind, input logic [7:0] b);
        t_request r;
        r.kind = kind;
        r.data = b;
        request_q.push_back(r);
        pushed_requests++;
        if (kind == crcpr_pkg::KIND_LINK) begin
            gen_pos = (gen_pos + 1) % PKT_LEN;
        end
    endfunction

    // A frame always starts on a frame boundary; leftover bytes of a broken frame are padded.
    task automatic send_frame(input logic [7:0] len, input logic [7:0] first, input t_body body,
                              input logic bad_crc);
        logic [7:0] crc;
        logic [7:0] b;
        int         spoil;
        while (gen_pos != 0) begin
            push_request(crcpr_pkg::KIND_LINK, rand_byte());
        end
        spoil = $urandom_range(1, DATA_BYTES - 1);
        push_request(crcpr_pkg::KIND_LINK, len);
        crc = crc8_update(cfg_crc_init, len);
        for (int k = 0; k < DATA_BYTES; k++) begin
            if (k == 0) begin
                b = first;
            end else if (body == BODY_RANDOM) begin
                b = rand_byte();
            end else if (body == BODY_SPOILED && k == spoil) begin
                b = 8'($urandom_range(0, 254));
            end else begin
                b = crcpr_pkg::FILL_BYTE;
            end
            push_request(crcpr_pkg::KIND_LINK, b);
            crc = crc8_update(crc, b);
        end
        crc = crc ^ cfg_crc_xorout;
        if (bad_crc) begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        push_request(crcpr_pkg::KIND_LINK, crc);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            crcpr_pkg::REG_ACK_CODE:   cfg_ack_code = val;
            crcpr_pkg::REG_RETX_CODE:  cfg_retx_code = val;
            crcpr_pkg::REG_ACK_CRC:    cfg_ack_crc = val;
            crcpr_pkg::REG_RETX_CRC:   cfg_retx_crc = val;
            crcpr_pkg::REG_CRC_INIT:   cfg_crc_init = val;
            crcpr_pkg::REG_CRC_XOROUT: cfg_crc_xorout = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] ack_code, input logic [7:0] retx_code,
                              input logic [7:0] ack_crc, input logic [7:0] retx_crc,
                              input logic [7:0] init, input logic [7:0] xorout);
        write_reg(crcpr_pkg::REG_ACK_CODE, ack_code);
        write_reg(crcpr_pkg::REG_RETX_CODE, retx_code);
        write_reg(crcpr_pkg::REG_ACK_CRC, ack_crc);
        write_reg(crcpr_pkg::REG_RETX_CRC, retx_crc);
        write_reg(crcpr_pkg::REG_CRC_INIT, init);
        write_reg(crcpr_pkg::REG_CRC_XOROUT, xorout);
    endtask

    // Waits until every request is taken and answered, then lets the last link byte finish.
    task automatic settle();
        while (accepted_requests != pushed_requests || reply_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_mix(input int budget);
        int stop_at;
        int pick;
        stop_at = pushed_requests + budget;
        while (pushed_requests < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                send_frame(rand_byte(), rand_byte(), BODY_RANDOM, 1'b0);
            end else if (pick < 46) begin
                send_frame(8'd1, cfg_ack_code, BODY_FILL, 1'b0);
            end else if (pick < 54) begin
                send_frame(8'd1, cfg_retx_code, BODY_FILL, 1'b0);
            end else if (pick < 62) begin
                send_frame(rand_byte(), rand_byte(), BODY_RANDOM, 1'b1);
            end else if (pick < 68) begin
                send_frame(8'd1, pick[0] ? cfg_ack_code : cfg_retx_code, BODY_SPOILED, pick[1]);
            end else if (pick < 72) begin
                send_frame(8'(pick), pick[0] ? cfg_ack_code : cfg_retx_code, BODY_FILL, 1'b0);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 3)) push_request(crcpr_pkg::KIND_READ, rand_byte());
            end else begin
                repeat ($urandom_range(1, 5)) push_request(crcpr_pkg::KIND_LINK, rand_byte());
            end
        end
    endtask

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_frame(8'd1, cfg_retx_code, BODY_FILL, 1'b0);
        push_request(crcpr_pkg::KIND_READ, 8'hFF);
        send_frame(8'd1, cfg_ack_code, BODY_FILL, 1'b0);
        send_frame(8'h40, rand_byte(), BODY_RANDOM, 1'b1);
        send_frame(8'd1, cfg_retx_code, BODY_FILL, 1'b0);
        send_frame(8'd1, cfg_retx_code, BODY_SPOILED, 1'b0);
        send_frame(8'd2, cfg_ack_code, BODY_FILL, 1'b0);
        repeat (3) push_request(crcpr_pkg::KIND_READ, rand_byte());
        settle();

        // Equal codes, and a full ring that wraps onto the read slot and reads as empty.
        set_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        write_reg(REG_SPARE_6, 8'hA5);
        write_reg(REG_SPARE_7, rand_byte());
        repeat (SLOTS) send_frame(rand_byte(), rand_byte(), BODY_RANDOM, 1'b0);
        push_request(crcpr_pkg::KIND_READ, rand_byte());
        send_frame(rand_byte(), rand_byte(), BODY_RANDOM, 1'b0);
        send_frame(8'd1, cfg_retx_code, BODY_FILL, 1'b0);
        repeat (3) push_request(crcpr_pkg::KIND_READ, rand_byte());
        settle();

        set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_mix(28);
        settle();

        set_config(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
        run_mix(28);
        settle();

        calm = 1'b1;
        set_config(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
        run_mix(24);
        settle();

        if (n_errors == 0) begin
            $display("crc_checked_packet_receiver_core regression: pass");
        end else begin
            $display("crc_checked_packet_receiver_core regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("crc_checked_packet_receiver_core regression: fail");
        $finish;
    end

endmodule
